// ----- src/sbrb_pkg.sv -----
// shared types and defaults for the segmented byte ring buffer
`default_nettype none

package sbrb_pkg;

   localparam int SEGMENT_BYTES_DEFAULT = 256;
   localparam int SEGMENT_COUNT_DEFAULT = 16;

   typedef enum logic [1:0] {
      ACT_PUSH    = 2'd0,
      ACT_READ    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_PUSH_FULL     = 2'd1,
      ST_RELEASE_CLAMP = 2'd2,
      ST_READ_RANGE    = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ----- src/sbrb_ram.sv -----
// byte store: single port synchronous ram with registered read data
`default_nettype none

module sbrb_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [7:0]        wdata,
   output logic      [7:0]        rdata
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/sbrb_ctrl.sv -----
// head, fill and write position bookkeeping plus store address generation
`default_nettype none

module sbrb_ctrl #(
   parameter int SEGMENT_BYTES = sbrb_pkg::SEGMENT_BYTES_DEFAULT,
   parameter int SEGMENT_COUNT = sbrb_pkg::SEGMENT_COUNT_DEFAULT,
   localparam int CAP    = SEGMENT_BYTES * SEGMENT_COUNT,
   localparam int CNT_W  = $clog2(CAP + 1),
   localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1,
   localparam int SEG_W  = $clog2(SEGMENT_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [1:0]       action,
   input  wire logic [7:0]       byte_in,
   input  wire logic [IDX_W-1:0] read_offset,
   input  wire logic [CNT_W-1:0] release_count,
   output logic                  mem_wr_en,
   output logic                  mem_rd_en,
   output logic      [IDX_W-1:0] mem_addr,
   output logic      [7:0]       mem_wdata,
   output sbrb_pkg::status_type  status,
   output logic      [CNT_W-1:0] stored,
   output logic      [CNT_W-1:0] free,
   output logic      [SEG_W-1:0] run
);

   localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);
   localparam logic [CNT_W:0]   CAP_X   = (CNT_W + 1)'(CAP);
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAP - 1);
   localparam logic [SEG_W-1:0] SEG_C   = SEG_W'(SEGMENT_BYTES);

   sbrb_pkg::action_type act;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] wpos_ff, wpos_in;
   logic [SEG_W-1:0] segleft_ff, segleft_in;

   logic             full;
   logic             clamp;
   logic             read_ok;
   logic [CNT_W-1:0] rel_n;
   logic [CNT_W:0]   rd_sum, rel_sum;
   logic [IDX_W-1:0] rd_addr, rel_head;

   assign act   = sbrb_pkg::action_type'(action);
   assign full  = (fill_ff == CAP_C);
   assign clamp = (release_count > fill_ff);
   assign rel_n = clamp ? fill_ff : release_count;

   // ring wrap: sums stay below twice the capacity
   assign rd_sum   = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(read_offset);
   assign rd_addr  = (rd_sum >= CAP_X) ? IDX_W'(rd_sum - CAP_X) : IDX_W'(rd_sum);
   assign rel_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(rel_n);
   assign rel_head = (rel_sum >= CAP_X) ? IDX_W'(rel_sum - CAP_X) : IDX_W'(rel_sum);

   assign read_ok  = ((CNT_W + 1)'(read_offset) < (CNT_W + 1)'(fill_ff));

   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      wpos_in    = wpos_ff;
      segleft_in = segleft_ff;
      status     = sbrb_pkg::ST_OK;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      mem_addr   = rd_addr;
      unique case (act)
         sbrb_pkg::ACT_PUSH: begin
            mem_addr = wpos_ff;
            if (full) begin
               status = sbrb_pkg::ST_PUSH_FULL;
            end else begin
               mem_wr_en  = take;
               fill_in    = fill_ff + CNT_W'(1);
               wpos_in    = (wpos_ff == LAST_IX) ? '0 : wpos_ff + IDX_W'(1);
               segleft_in = (segleft_ff == SEG_W'(1)) ? SEG_C : segleft_ff - SEG_W'(1);
            end
         end
         sbrb_pkg::ACT_READ: begin
            if (read_ok) begin
               mem_rd_en = take;
            end else begin
               status = sbrb_pkg::ST_READ_RANGE;
            end
         end
         sbrb_pkg::ACT_RELEASE: begin
            // write position is unchanged by a release
            if (clamp) begin
               status = sbrb_pkg::ST_RELEASE_CLAMP;
            end
            head_in = rel_head;
            fill_in = fill_ff - rel_n;
         end
         sbrb_pkg::ACT_CLEAR: begin
            head_in    = '0;
            fill_in    = '0;
            wpos_in    = '0;
            segleft_in = SEG_C;
         end
         default: begin
            status = sbrb_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         fill_ff    <= '0;
         wpos_ff    <= '0;
         segleft_ff <= SEG_C;
      end else if (take) begin
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         wpos_ff    <= wpos_in;
         segleft_ff <= segleft_in;
      end
   end

   assign mem_wdata = byte_in;
   assign stored    = fill_ff;
   assign free      = CAP_C - fill_ff;
   assign run       = (CNT_W'(segleft_ff) < free) ? segleft_ff : SEG_W'(free);

endmodule

`default_nettype wire

// ----- src/segmented_byte_ring_buffer_core.sv -----
// segmented byte ring buffer: handshake, result staging and output register
//
//   channel  prefix  direction  carries
//   request  req_    in         action, byte_in, read_offset, release_count
//   response rsp_    out        byte_out, stored_bytes, free_bytes,
//                               run_to_segment_end, status
//
// one word per cycle unless the response stalls; the store is read on the edge
// that accepts a request word, and the output register loads the staged result
// when the staging stage advances.
// reset is synchronous and empties the ring; the byte store is not cleared.
// a stalled response holds the staging stage, which then stalls requests.
`default_nettype none

module segmented_byte_ring_buffer_core #(
   parameter int SEGMENT_BYTES = sbrb_pkg::SEGMENT_BYTES_DEFAULT,
   parameter int SEGMENT_COUNT = sbrb_pkg::SEGMENT_COUNT_DEFAULT,
   localparam int CAP    = SEGMENT_BYTES * SEGMENT_COUNT,
   localparam int CNT_W  = $clog2(CAP + 1),
   localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1,
   localparam int SEG_W  = $clog2(SEGMENT_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_action,
   input  wire logic [7:0]       req_byte_in,
   input  wire logic [IDX_W-1:0] req_read_offset,
   input  wire logic [CNT_W-1:0] req_release_count,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [7:0]       rsp_byte_out,
   output logic      [CNT_W-1:0] rsp_stored_bytes,
   output logic      [CNT_W-1:0] rsp_free_bytes,
   output logic      [SEG_W-1:0] rsp_run_to_segment_end,
   output logic      [1:0]       rsp_status
);

   logic                 take;
   logic                 s1_adv;
   logic                 mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]     mem_addr;
   logic [7:0]           mem_wdata, mem_rdata;
   sbrb_pkg::status_type status;
   logic [CNT_W-1:0]     stored, free;
   logic [SEG_W-1:0]     run;

   logic                 s1_valid_ff, s1_valid_in;
   sbrb_pkg::status_type s1_status_ff;
   logic                 s1_read_ok_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff;
   logic [CNT_W-1:0]     rsp_stored_ff, rsp_free_ff;
   logic [SEG_W-1:0]     rsp_run_ff;
   sbrb_pkg::status_type rsp_status_ff;

   sbrb_ctrl #(
      .SEGMENT_BYTES(SEGMENT_BYTES),
      .SEGMENT_COUNT(SEGMENT_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .action       (req_action),
      .byte_in      (req_byte_in),
      .read_offset  (req_read_offset),
      .release_count(req_release_count),
      .mem_wr_en    (mem_wr_en),
      .mem_rd_en    (mem_rd_en),
      .mem_addr     (mem_addr),
      .mem_wdata    (mem_wdata),
      .status       (status),
      .stored       (stored),
      .free         (free),
      .run          (run)
   );

   sbrb_ram #(
      .DEPTH (CAP),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock(clock),
      .wr_en(mem_wr_en),
      .rd_en(mem_rd_en),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   // staging moves on when the output register is empty or being drained
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign take      = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_status_ff  <= status;
         s1_read_ok_ff <= mem_rd_en;
      end
      // counters already hold the post-word state of the staged word
      if (s1_valid_ff && s1_adv) begin
         rsp_byte_ff   <= s1_read_ok_ff ? mem_rdata : 8'd0;
         rsp_stored_ff <= stored;
         rsp_free_ff   <= free;
         rsp_run_ff    <= run;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_byte_out           = rsp_byte_ff;
   assign rsp_stored_bytes       = rsp_stored_ff;
   assign rsp_free_bytes         = rsp_free_ff;
   assign rsp_run_to_segment_end = rsp_run_ff;
   assign rsp_status             = 2'(rsp_status_ff);

endmodule

`default_nettype wire

// ----- tb/segmented_byte_ring_buffer_core_tb.sv -----
// testbench for segmented_byte_ring_buffer_core: directed table, head offset pass and random mix
module segmented_byte_ring_buffer_core_tb;

   localparam int SEG_BYTES      = sbrb_pkg::SEGMENT_BYTES_DEFAULT;
   localparam int RING_BYTES     = sbrb_pkg::SEGMENT_BYTES_DEFAULT *
                                   sbrb_pkg::SEGMENT_COUNT_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_HOLD  = 300;

   typedef struct packed {
      logic [7:0]           data;
      logic [12:0]          stored;
      logic [12:0]          vacant;
      logic [8:0]           run;
      sbrb_pkg::status_type status;
   } reply_type;

   typedef struct {
      sbrb_pkg::action_type act;
      logic [7:0]           data;
      logic [11:0]          offset;
      logic [12:0]          count;
      bit                   typed;
      reply_type            want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [7:0]  req_byte_in;
   logic [11:0] req_read_offset;
   logic [12:0] req_release_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_byte_out;
   logic [12:0] rsp_stored_bytes;
   logic [12:0] rsp_free_bytes;
   logic [8:0]  rsp_run_to_segment_end;
   logic [1:0]  rsp_status;

   // shadow copy of the ring
   logic [7:0]  shadow_store [0:RING_BYTES-1];
   logic [11:0] shadow_head;
   logic [12:0] shadow_fill;

   reply_type    replies_due [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           sender_quiet = 1'b0;
   bit           hold_receiver = 1'b0;

   segmented_byte_ring_buffer_core uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_byte_in            (req_byte_in),
      .req_read_offset        (req_read_offset),
      .req_release_count      (req_release_count),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_byte_out           (rsp_byte_out),
      .rsp_stored_bytes       (rsp_stored_bytes),
      .rsp_free_bytes         (rsp_free_bytes),
      .rsp_run_to_segment_end (rsp_run_to_segment_end),
      .rsp_status             (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // advances the shadow ring by one word and returns the reply it should produce
   function automatic reply_type apply_ring_word(sbrb_pkg::action_type act, logic [7:0] data,
                                                 logic [11:0] offset, logic [12:0] count);
      reply_type   r;
      logic [12:0] take;
      logic [11:0] pos;
      int          seg_left;
      int          vacant;
      r = '0;
      r.status = sbrb_pkg::ST_OK;
      case (act)
         sbrb_pkg::ACT_PUSH: begin
            if (shadow_fill == RING_BYTES) begin
               r.status = sbrb_pkg::ST_PUSH_FULL;
            end else begin
               pos = shadow_head + shadow_fill[11:0];
               shadow_store[pos] = data;
               shadow_fill = shadow_fill + 13'd1;
            end
         end
         sbrb_pkg::ACT_READ: begin
            if ({1'b0, offset} >= shadow_fill) begin
               r.status = sbrb_pkg::ST_READ_RANGE;
            end else begin
               pos = shadow_head + offset;
               r.data = shadow_store[pos];
            end
         end
         sbrb_pkg::ACT_RELEASE: begin
            take = count;
            if (count > shadow_fill) begin
               take = shadow_fill;
               r.status = sbrb_pkg::ST_RELEASE_CLAMP;
            end
            // a full-ring release moves the head by a whole lap
            shadow_head = shadow_head + take[11:0];
            shadow_fill = shadow_fill - take;
         end
         sbrb_pkg::ACT_CLEAR: begin
            shadow_head = '0;
            shadow_fill = '0;
         end
      endcase
      vacant = RING_BYTES - int'(shadow_fill);
      pos = shadow_head + shadow_fill[11:0];
      seg_left = SEG_BYTES - (int'(pos) % SEG_BYTES);
      r.stored = shadow_fill;
      r.vacant = 13'(vacant);
      r.run = 9'((seg_left < vacant) ? seg_left : vacant);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < 100)
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic check_reply();
      reply_type want;
      if (replies_due.size() == 0) begin
         report_mismatch("word with nothing due, stored_bytes", int'(rsp_stored_bytes), -1);
      end else begin
         want = replies_due.pop_front();
         if (rsp_byte_out !== want.data)
            report_mismatch("byte_out", int'(rsp_byte_out), int'(want.data));
         if (rsp_stored_bytes !== want.stored)
            report_mismatch("stored_bytes", int'(rsp_stored_bytes), int'(want.stored));
         if (rsp_free_bytes !== want.vacant)
            report_mismatch("free_bytes", int'(rsp_free_bytes), int'(want.vacant));
         if (rsp_run_to_segment_end !== want.run)
            report_mismatch("run_to_segment_end", int'(rsp_run_to_segment_end),
                            int'(want.run));
         if (rsp_status !== want.status)
            report_mismatch("status", int'(rsp_status), int'(want.status));
      end
   endtask

   task automatic send_word(sbrb_pkg::action_type act, logic [7:0] data, logic [11:0] offset,
                            logic [12:0] count, bit typed, reply_type want);
      int        gap;
      reply_type predicted;
      gap = sender_quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predicted = apply_ring_word(act, data, offset, count);
      replies_due.push_back(typed ? want : predicted);
      req_valid         <= 1'b1;
      req_action        <= act;
      req_byte_in       <= data;
      req_read_offset   <= offset;
      req_release_count <= count;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic plain_row(sbrb_pkg::action_type act, logic [7:0] data, logic [11:0] offset,
                            logic [12:0] count);
      stim_row_type row;
      row.act = act;
      row.data = data;
      row.offset = offset;
      row.count = count;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endtask

   task automatic checked_row(sbrb_pkg::action_type act, logic [7:0] data, logic [11:0] offset,
                              logic [12:0] count, logic [7:0] w_data, logic [12:0] w_stored,
                              logic [12:0] w_vacant, logic [8:0] w_run,
                              sbrb_pkg::status_type w_status);
      stim_row_type row;
      row.act = act;
      row.data = data;
      row.offset = offset;
      row.count = count;
      row.typed = 1'b1;
      row.want.data = w_data;
      row.want.stored = w_stored;
      row.want.vacant = w_vacant;
      row.want.run = w_run;
      row.want.status = w_status;
      directed_rows.push_back(row);
   endtask

   task automatic send_random_word();
      int                   pick;
      int                   sel;
      logic [11:0]          offset;
      logic [12:0]          count;
      sbrb_pkg::action_type act;
      pick = $urandom_range(0, 99);
      offset = 12'($urandom);
      count = 13'($urandom_range(0, RING_BYTES));
      if (pick < 48) begin
         act = sbrb_pkg::ACT_PUSH;
      end else if (pick < 78) begin
         act = sbrb_pkg::ACT_READ;
         if (shadow_fill != 0 && $urandom_range(0, 9) != 0)
            offset = 12'($urandom_range(0, shadow_fill - 13'd1));
      end else if (pick < 97) begin
         act = sbrb_pkg::ACT_RELEASE;
         sel = $urandom_range(0, 9);
         if (sel == 0)
            count = 13'(RING_BYTES);
         else if (sel == 1)
            count = 13'($urandom_range(0, RING_BYTES));
         else if (sel == 2)
            count = shadow_fill;
         else
            count = 13'($urandom_range(0, (shadow_fill < 13'd8) ? shadow_fill : 13'd8));
      end else begin
         act = sbrb_pkg::ACT_CLEAR;
      end
      send_word(act, 8'($urandom), offset, count, 1'b0, '0);
   endtask

   // receiver: random hold-off per word, one long hold when asked
   initial begin
      int hold;
      bit quiet;
      quiet = 1'b0;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
         if (hold_receiver) begin
            hold = PRESSURE_HOLD;
            hold_receiver = 1'b0;
         end else begin
            hold = quiet ? 0 : $urandom_range(0, 12);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         check_reply();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("segmented_byte_ring_buffer_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          i;
      logic [12:0] chunk;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = sbrb_pkg::ACT_PUSH;
      req_byte_in = '0;
      req_read_offset = '0;
      req_release_count = '0;
      shadow_head = '0;
      shadow_fill = '0;

      checked_row(sbrb_pkg::ACT_READ, 8'h00, 12'd0, 13'd0,
                  8'h00, 13'd0, 13'd4096, 9'd256, sbrb_pkg::ST_READ_RANGE);
      checked_row(sbrb_pkg::ACT_RELEASE, 8'hff, 12'd4095, 13'd0,
                  8'h00, 13'd0, 13'd4096, 9'd256, sbrb_pkg::ST_OK);
      checked_row(sbrb_pkg::ACT_RELEASE, 8'h00, 12'd0, 13'd4096,
                  8'h00, 13'd0, 13'd4096, 9'd256, sbrb_pkg::ST_RELEASE_CLAMP);
      checked_row(sbrb_pkg::ACT_PUSH, 8'h00, 12'd4095, 13'd4096,
                  8'h00, 13'd1, 13'd4095, 9'd255, sbrb_pkg::ST_OK);
      checked_row(sbrb_pkg::ACT_PUSH, 8'hff, 12'd0, 13'd0,
                  8'h00, 13'd2, 13'd4094, 9'd254, sbrb_pkg::ST_OK);
      plain_row(sbrb_pkg::ACT_PUSH, 8'h5a, 12'd7, 13'd3);
      checked_row(sbrb_pkg::ACT_READ, 8'h00, 12'd0, 13'd0,
                  8'h00, 13'd3, 13'd4093, 9'd253, sbrb_pkg::ST_OK);
      checked_row(sbrb_pkg::ACT_READ, 8'h00, 12'd1, 13'd4096,
                  8'hff, 13'd3, 13'd4093, 9'd253, sbrb_pkg::ST_OK);
      plain_row(sbrb_pkg::ACT_READ, 8'h11, 12'd2, 13'd0);
      checked_row(sbrb_pkg::ACT_READ, 8'h00, 12'd3, 13'd0,
                  8'h00, 13'd3, 13'd4093, 9'd253, sbrb_pkg::ST_READ_RANGE);
      checked_row(sbrb_pkg::ACT_READ, 8'hff, 12'd4095, 13'd0,
                  8'h00, 13'd3, 13'd4093, 9'd253, sbrb_pkg::ST_READ_RANGE);
      // clear keeps the store but empties the ring
      checked_row(sbrb_pkg::ACT_CLEAR, 8'haa, 12'd5, 13'd9,
                  8'h00, 13'd0, 13'd4096, 9'd256, sbrb_pkg::ST_OK);
      plain_row(sbrb_pkg::ACT_PUSH, 8'ha5, 12'd0, 13'd0);
      plain_row(sbrb_pkg::ACT_READ, 8'h00, 12'd0, 13'd0);
      plain_row(sbrb_pkg::ACT_RELEASE, 8'h00, 12'd0, 13'd1);
      plain_row(sbrb_pkg::ACT_PUSH, 8'h3c, 12'd0, 13'd0);
      plain_row(sbrb_pkg::ACT_PUSH, 8'hc3, 12'd0, 13'd0);
      plain_row(sbrb_pkg::ACT_READ, 8'h00, 12'd1, 13'd0);
      checked_row(sbrb_pkg::ACT_RELEASE, 8'h00, 12'd0, 13'd4096,
                  8'h00, 13'd0, 13'd4096, 9'd253, sbrb_pkg::ST_RELEASE_CLAMP);
      checked_row(sbrb_pkg::ACT_READ, 8'h00, 12'd0, 13'd0,
                  8'h00, 13'd0, 13'd4096, 9'd253, sbrb_pkg::ST_READ_RANGE);
      checked_row(sbrb_pkg::ACT_RELEASE, 8'h00, 12'd0, 13'd0,
                  8'h00, 13'd0, 13'd4096, 9'd253, sbrb_pkg::ST_OK);
      checked_row(sbrb_pkg::ACT_CLEAR, 8'hff, 12'd4095, 13'd4096,
                  8'h00, 13'd0, 13'd4096, 9'd256, sbrb_pkg::ST_OK);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (k % 8 == 0)
            sender_quiet = ($urandom_range(0, 1) == 0);
         send_word(directed_rows[k].act, directed_rows[k].data, directed_rows[k].offset,
                   directed_rows[k].count, directed_rows[k].typed, directed_rows[k].want);
      end

      // move the head off zero, then refill across segment boundaries
      repeat (200) send_word(sbrb_pkg::ACT_PUSH, 8'($urandom), 12'($urandom),
                             13'($urandom_range(0, RING_BYTES)), 1'b0, '0);
      while (shadow_fill != 0) begin
         chunk = 13'($urandom_range(1, 64));
         if (chunk > shadow_fill)
            chunk = shadow_fill;
         send_word(sbrb_pkg::ACT_RELEASE, 8'($urandom), 12'($urandom), chunk, 1'b0, '0);
      end
      repeat (60) send_word(sbrb_pkg::ACT_PUSH, 8'($urandom), 12'($urandom),
                            13'($urandom_range(0, RING_BYTES)), 1'b0, '0);
      send_word(sbrb_pkg::ACT_READ, 8'($urandom), 12'd4095,
                13'($urandom_range(0, RING_BYTES)), 1'b0, '0);
      send_word(sbrb_pkg::ACT_READ, 8'($urandom), 12'd0,
                13'($urandom_range(0, RING_BYTES)), 1'b0, '0);
      repeat (18) send_word(sbrb_pkg::ACT_READ, 8'($urandom), 12'($urandom),
                            13'($urandom_range(0, RING_BYTES)), 1'b0, '0);
      send_word(sbrb_pkg::ACT_RELEASE, 8'($urandom), 12'($urandom), 13'(RING_BYTES),
                1'b0, '0);

      for (i = 0; i < 28; i++) begin
         sender_quiet = ($urandom_range(0, 2) == 0);
         if (i == 12) begin
            // receiver holds off while words keep coming
            hold_receiver = 1'b1;
            sender_quiet = 1'b1;
         end
         repeat (30) send_random_word();
      end

      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("segmented_byte_ring_buffer_core test passed");
      else
         $display("segmented_byte_ring_buffer_core test failed");
      $finish;
   end

endmodule
